>>> rtl/core/quaternion_normaliser_unit_defines.svh
// Assertion macros for the quaternion normaliser.
// Each macro takes a label and two expressions and uses the top-level signals clk and rst_n.
`ifndef QUATERNION_NORMALISER_UNIT_DEFINES_SVH
`define QUATERNION_NORMALISER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define QNU_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("quaternion normaliser implication check failed");
`define QNU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("quaternion normaliser next-cycle check failed");
`else
`define QNU_ASSERT_IMPL(label, ante, cons)
`define QNU_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/core/qnorm_pkg.sv
package qnorm_pkg;

  localparam int NUM_COMPS = 4;

  // Control that travels with each item down the pipeline.
  typedef struct packed {
    logic                 vld;
    logic                 zero;
    logic [NUM_COMPS-1:0] neg;
  } ctl_t;

endpackage

>>> rtl/core/qnorm_step.sv
module qnorm_step #(
  parameter int DW  = 64,
  parameter int QW  = 15,
  parameter int SW  = 34,
  parameter int BIT = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  qnorm_pkg::ctl_t     ctl_i,
  input  logic [SW-1:0]       s_i,
  input  logic [DW-1:0]       r_i [qnorm_pkg::NUM_COMPS],
  input  logic [DW-1:0]       p_i [qnorm_pkg::NUM_COMPS],
  input  logic [QW-1:0]       q_i [qnorm_pkg::NUM_COMPS],
  output qnorm_pkg::ctl_t     ctl_o,
  output logic [SW-1:0]       s_o,
  output logic [DW-1:0]       r_o [qnorm_pkg::NUM_COMPS],
  output logic [DW-1:0]       p_o [qnorm_pkg::NUM_COMPS],
  output logic [QW-1:0]       q_o [qnorm_pkg::NUM_COMPS]
);
  import qnorm_pkg::*;

  // One result bit per lane: adding 2^BIT to q raises q*q*S by
  // 2*q*S*2^BIT + S*2^(2*BIT), which is tested against the remainder.
  logic [DW-1:0] delta [NUM_COMPS];
  logic [NUM_COMPS-1:0] take;
  logic [DW-1:0] r_nxt [NUM_COMPS];
  logic [DW-1:0] p_nxt [NUM_COMPS];
  logic [QW-1:0] q_nxt [NUM_COMPS];
  ctl_t          ctl_r;
  logic [SW-1:0] s_r;
  logic [DW-1:0] r_r [NUM_COMPS];
  logic [DW-1:0] p_r [NUM_COMPS];
  logic [QW-1:0] q_r [NUM_COMPS];

  always_comb begin
    for (int i = 0; i < NUM_COMPS; i++) begin
      delta[i] = (p_i[i] << (BIT + 1)) + (DW'(s_i) << (2 * BIT));
      take[i]  = (delta[i] <= r_i[i]);
      r_nxt[i] = take[i] ? (r_i[i] - delta[i]) : r_i[i];
      p_nxt[i] = take[i] ? (p_i[i] + (DW'(s_i) << BIT)) : p_i[i];
      q_nxt[i] = q_i[i] | (QW'(take[i]) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= s_i;
      for (int i = 0; i < NUM_COMPS; i++) begin
        r_r[i] <= r_nxt[i];
        p_r[i] <= p_nxt[i];
        q_r[i] <= q_nxt[i];
      end
    end
  end

  assign ctl_o = ctl_r;
  assign s_o   = s_r;
  assign r_o   = r_r;
  assign p_o   = p_r;
  assign q_o   = q_r;

endmodule

>>> rtl/core/quaternion_normaliser_unit.sv
// Quaternion normaliser: turns one quaternion of four signed fixed-point
// components into a unit quaternion, each component divided by the norm.
// The input channel (in_valid, in_stall, in_comp_*) takes one item per
// cycle while in_stall is low; the result channel (out_valid, out_stall,
// out_unit_*, out_zero_norm) gives exactly one result item per input item,
// in order. The pipeline registers the magnitudes, then the squares, then
// the sum of squares, then each result bit in its own restoring division
// stage, and last the output register that restores the sign.
// Throughput is one item per cycle while out_stall does not hold back a
// waiting result, set by the fully pipelined bit stages.
// When all four components are zero the outputs are zero and out_zero_norm
// is set. Results are rounded toward zero.
// Reset clears every valid bit, so the pipeline comes up empty.
// While out_stall holds back a waiting result the whole pipeline freezes
// and in_stall is raised; no item is lost or repeated. Empty stages never
// block, so input is taken whenever the output register is free.
`include "quaternion_normaliser_unit_defines.svh"
module quaternion_normaliser_unit #(
  parameter int COMP_WIDTH = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COMP_WIDTH-1:0] in_comp_w,
  input  logic signed [COMP_WIDTH-1:0] in_comp_x,
  input  logic signed [COMP_WIDTH-1:0] in_comp_y,
  input  logic signed [COMP_WIDTH-1:0] in_comp_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COMP_WIDTH-1:0] out_unit_w,
  output logic signed [COMP_WIDTH-1:0] out_unit_x,
  output logic signed [COMP_WIDTH-1:0] out_unit_y,
  output logic signed [COMP_WIDTH-1:0] out_unit_z,
  output logic                         out_zero_norm
);
  import qnorm_pkg::*;

  localparam int SQW = 2 * COMP_WIDTH;
  localparam int SW  = SQW + 2;
  localparam int DW  = 2 * COMP_WIDTH + 2 * FRAC_BITS + 4;
  localparam int QW  = FRAC_BITS + 1;
  localparam int NST = FRAC_BITS + 1;
  localparam logic signed [COMP_WIDTH-1:0] ULIM = COMP_WIDTH'(1) << FRAC_BITS;

  // The pipeline advances as a whole whenever the output register is free.
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic [COMP_WIDTH-1:0] cin [NUM_COMPS];
  assign cin[0] = in_comp_w;
  assign cin[1] = in_comp_x;
  assign cin[2] = in_comp_y;
  assign cin[3] = in_comp_z;

  // Stage A: magnitudes and signs. The most negative code maps to 2^(W-1),
  // which the unsigned W-bit negate already gives.
  ctl_t                  ctl_a_r;
  logic [COMP_WIDTH-1:0] mag_a_r [NUM_COMPS];
  logic [NUM_COMPS-1:0]  neg_a;

  always_comb begin
    for (int i = 0; i < NUM_COMPS; i++) begin
      neg_a[i] = cin[i][COMP_WIDTH-1];
    end
  end

  // Stage B: squares, one multiplier per lane.
  ctl_t           ctl_b_r;
  logic [SQW-1:0] sq_b_r [NUM_COMPS];

  // Stage C: the sum of squares and the scaled target of each lane.
  ctl_t          ctl_c_r;
  logic [SW-1:0] s_nxt;
  logic [SW-1:0] s_c_r;
  logic [DW-1:0] r_c_r [NUM_COMPS];

  always_comb begin
    s_nxt = '0;
    for (int i = 0; i < NUM_COMPS; i++) begin
      s_nxt = s_nxt + SW'(sq_b_r[i]);
    end
  end

  logic [SW-1:0] s_st [NST+1];
  logic [DW-1:0] r_st [NST+1][NUM_COMPS];
  logic [DW-1:0] p_st [NST+1][NUM_COMPS];
  logic [QW-1:0] q_st [NST+1][NUM_COMPS];
  ctl_t          ctl_st [NST+1];

  assign ctl_st[0] = ctl_c_r;
  assign s_st[0]   = s_c_r;

  for (genvar i = 0; i < NUM_COMPS; i++) begin : g_init
    assign r_st[0][i] = r_c_r[i];
    assign p_st[0][i] = '0;
    assign q_st[0][i] = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
      ctl_c_r <= '0;
    end else if (en) begin
      ctl_a_r <= '{vld: in_valid, zero: 1'b0, neg: neg_a};
      ctl_b_r <= ctl_a_r;
      ctl_c_r <= '{vld: ctl_b_r.vld, zero: (s_nxt == '0), neg: ctl_b_r.neg};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_c_r <= s_nxt;
      for (int i = 0; i < NUM_COMPS; i++) begin
        mag_a_r[i] <= neg_a[i] ? (COMP_WIDTH'(0) - cin[i]) : cin[i];
        sq_b_r[i]  <= SQW'(mag_a_r[i]) * SQW'(mag_a_r[i]);
        r_c_r[i]   <= DW'(sq_b_r[i]) << (2 * FRAC_BITS);
      end
    end
  end

  // One restoring stage per result bit, most significant bit first.
  for (genvar k = 0; k < NST; k++) begin : g_step
    qnorm_step #(
      .DW (DW),
      .QW (QW),
      .SW (SW),
      .BIT(FRAC_BITS - k)
    ) u_step (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (en),
      .ctl_i(ctl_st[k]),
      .s_i  (s_st[k]),
      .r_i  (r_st[k]),
      .p_i  (p_st[k]),
      .q_i  (q_st[k]),
      .ctl_o(ctl_st[k+1]),
      .s_o  (s_st[k+1]),
      .r_o  (r_st[k+1]),
      .p_o  (p_st[k+1]),
      .q_o  (q_st[k+1])
    );
  end

  // Output register: restore the sign, force zero on a zero norm.
  logic                  out_vld_r;
  logic                  zero_r;
  logic [COMP_WIDTH-1:0] unit_r [NUM_COMPS];
  logic [COMP_WIDTH-1:0] unit_nxt [NUM_COMPS];

  always_comb begin
    for (int i = 0; i < NUM_COMPS; i++) begin
      if (ctl_st[NST].zero) begin
        unit_nxt[i] = '0;
      end else if (ctl_st[NST].neg[i]) begin
        unit_nxt[i] = COMP_WIDTH'(0) - COMP_WIDTH'(q_st[NST][i]);
      end else begin
        unit_nxt[i] = COMP_WIDTH'(q_st[NST][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= ctl_st[NST].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r <= ctl_st[NST].zero;
      unit_r <= unit_nxt;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_zero_norm = zero_r;
  assign out_unit_w    = unit_r[0];
  assign out_unit_x    = unit_r[1];
  assign out_unit_y    = unit_r[2];
  assign out_unit_z    = unit_r[3];

  // A zero norm must give an all-zero quaternion.
  `QNU_ASSERT_IMPL(a_zero_out, out_valid && out_zero_norm,
    out_unit_w == '0 && out_unit_x == '0 && out_unit_y == '0 && out_unit_z == '0)
  // A nonzero norm leaves at least one nonzero component.
  `QNU_ASSERT_IMPL(a_nonzero_out, out_valid && !out_zero_norm,
    out_unit_w != '0 || out_unit_x != '0 || out_unit_y != '0 || out_unit_z != '0)
  // Every component stays within plus or minus one.
  `QNU_ASSERT_IMPL(a_range, out_valid,
    out_unit_w <= ULIM && out_unit_w >= -ULIM && out_unit_x <= ULIM &&
    out_unit_x >= -ULIM && out_unit_y <= ULIM && out_unit_y >= -ULIM &&
    out_unit_z <= ULIM && out_unit_z >= -ULIM)
  // A stalled result is still offered in the next cycle.
  `QNU_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid)

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the quaternion normaliser.
// A directed table comes first; then random quaternions arrive in bursts.
// Every accepted input item gets an expected unit quaternion, from the
// table where known, else by an independent square-root-free bit-serial
// search; each result item is checked against the oldest expectation.
module tb_top;

  localparam int CW = 16;
  localparam int FB = 14;
  localparam int N_DIRECTED = 20;
  localparam int N_RANDOM = 1150;
  localparam int LATENCY = FB + 5;

  typedef struct packed {
    logic signed [CW-1:0] w;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [CW-1:0] w;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 zero;
  } unit_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [CW-1:0] in_comp_w, in_comp_x, in_comp_y, in_comp_z;
  logic out_valid;
  logic out_stall;
  logic signed [CW-1:0] out_unit_w, out_unit_x, out_unit_y, out_unit_z;
  logic out_zero_norm;

  quaternion_normaliser_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_comp_w(in_comp_w), .in_comp_x(in_comp_x),
    .in_comp_y(in_comp_y), .in_comp_z(in_comp_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_unit_w(out_unit_w), .out_unit_x(out_unit_x),
    .out_unit_y(out_unit_y), .out_unit_z(out_unit_z),
    .out_zero_norm(out_zero_norm)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Expected unit quaternions, oldest first.
  unit_t pending_units[$];
  int mismatches = 0;
  bit stim_done = 1'b0;

  // Magnitude of one component; the most negative code stays 2^(CW-1).
  function automatic logic [CW-1:0] comp_mag(logic signed [CW-1:0] c);
    return c[CW-1] ? (~c + 1'b1) : c;
  endfunction

  // Largest q <= 2^FB with q*q*S <= c*c*2^(2*FB), signed like c.
  function automatic logic signed [CW-1:0] scale_comp(logic signed [CW-1:0] c,
                                                       logic [127:0] sum_sq);
    logic [127:0] rhs;
    logic [127:0] trial;
    logic [CW-1:0] q;
    logic [CW-1:0] t;
    rhs = ({112'd0, comp_mag(c)} * {112'd0, comp_mag(c)}) << (2 * FB);
    q = '0;
    for (int b = FB; b >= 0; b--) begin
      t = q | (CW'(1) << b);
      if (t > (CW'(1) << FB)) continue;
      trial = sum_sq * ({112'd0, t} * {112'd0, t});
      if (trial <= rhs) q = t;
    end
    return c[CW-1] ? -$signed(q) : $signed(q);
  endfunction

  function automatic unit_t normalise(quat_t q);
    unit_t u;
    logic [127:0] s;
    s = {112'd0, comp_mag(q.w)} * {112'd0, comp_mag(q.w)}
      + {112'd0, comp_mag(q.x)} * {112'd0, comp_mag(q.x)}
      + {112'd0, comp_mag(q.y)} * {112'd0, comp_mag(q.y)}
      + {112'd0, comp_mag(q.z)} * {112'd0, comp_mag(q.z)};
    if (s == 0) begin
      u = '0;
      u.zero = 1'b1;
    end else begin
      u.w = scale_comp(q.w, s);
      u.x = scale_comp(q.x, s);
      u.y = scale_comp(q.y, s);
      u.z = scale_comp(q.z, s);
      u.zero = 1'b0;
    end
    return u;
  endfunction

  // Directed table. Rows with has_known set carry a result read off by eye;
  // the rest rely on the predictor.
  quat_t directed_in[N_DIRECTED];
  unit_t directed_out[N_DIRECTED];
  bit    has_known[N_DIRECTED];

  initial begin
    for (int i = 0; i < N_DIRECTED; i++) has_known[i] = 1'b0;
    // The all-zero quaternion raises the zero-norm flag.
    directed_in[0] = '{16'sd0, 16'sd0, 16'sd0, 16'sd0};
    directed_out[0] = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1}; has_known[0] = 1;
    // A single nonzero component normalises to exactly plus or minus one.
    directed_in[1] = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
    directed_out[1] = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0}; has_known[1] = 1;
    directed_in[2] = '{16'sd0, -16'sd1, 16'sd0, 16'sd0};
    directed_out[2] = '{16'sd0, -16'sd16384, 16'sd0, 16'sd0, 1'b0}; has_known[2] = 1;
    directed_in[3] = '{16'sd0, 16'sd0, 16'sd32767, 16'sd0};
    directed_out[3] = '{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 1'b0}; has_known[3] = 1;
    // The most negative code taken alone.
    directed_in[4] = '{16'sd0, 16'sd0, 16'sd0, -16'sd32768};
    directed_out[4] = '{16'sd0, 16'sd0, 16'sd0, -16'sd16384, 1'b0}; has_known[4] = 1;
    directed_in[5] = '{16'sd1, 16'sd0, 16'sd0, 16'sd0};
    directed_out[5] = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0}; has_known[5] = 1;
    // Everything else goes through the predictor.
    directed_in[6]  = '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768};
    directed_in[7]  = '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767};
    directed_in[8]  = '{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768};
    directed_in[9]  = '{16'sd1, 16'sd1, 16'sd1, 16'sd1};
    directed_in[10] = '{16'sd1, -16'sd1, 16'sd0, 16'sd0};
    directed_in[11] = '{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192};
    directed_in[12] = '{16'sd32767, 16'sd1, 16'sd0, 16'sd0};
    directed_in[13] = '{-16'sd1, -16'sd1, -16'sd1, 16'sd32767};
    directed_in[14] = '{16'sd3, 16'sd4, 16'sd0, 16'sd0};
    directed_in[15] = '{16'sd21845, -16'sd21846, 16'sd10922, -16'sd5461};
    directed_in[16] = '{-16'sd32768, 16'sd1, 16'sd0, 16'sd0};
    directed_in[17] = '{16'sh5555, 16'shAAAA, 16'sh7FFF, 16'sh0001};
    directed_in[18] = '{16'shAAAA, 16'sh5555, 16'sh8001, 16'sh7FFE};
    directed_in[19] = '{16'sd11585, 16'sd11585, 16'sd0, 16'sd0};
  end

  function automatic logic signed [CW-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return $signed(CW'($urandom_range(0, 3)) - CW'(2));
      1: return 16'sh8000;
      2: return 16'sh7FFF;
      3: return $signed(CW'($urandom_range(0, 511)) - CW'(256));
      default: return $signed(CW'($urandom));
    endcase
  endfunction

  // Present one item and hold it until the block takes it. Valid stays high
  // across back-to-back items, so it is only lowered for a real gap.
  task automatic send_item(quat_t q, unit_t u);
    in_valid  <= 1'b1;
    in_comp_w <= q.w;
    in_comp_x <= q.x;
    in_comp_y <= q.y;
    in_comp_z <= q.z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_units.push_back(u);
  endtask

  task automatic idle_gap(int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Sender.
  initial begin
    quat_t q;
    int burst;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_comp_w = '0;
    in_comp_x = '0;
    in_comp_y = '0;
    in_comp_z = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_item(directed_in[i],
                has_known[i] ? directed_out[i] : normalise(directed_in[i]));
      if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 3));
    end

    // Hold off until the pipeline has drained completely.
    idle_gap(1);
    while (pending_units.size() != 0) @(posedge clk);

    for (int n = 0; n < N_RANDOM; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < N_RANDOM; k++, n++) begin
        q.w = rand_comp();
        q.x = rand_comp();
        q.y = rand_comp();
        q.z = rand_comp();
        if ($urandom_range(0, 49) == 0) q = '0;
        send_item(q, normalise(q));
      end
      idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8));
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver stall pattern: long phases of free flow, random back-pressure
  // or heavy back-pressure, each picked at random.
  int stall_mode = 0;
  int mode_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Result checker.
  always @(posedge clk) begin
    unit_t got;
    unit_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_unit_w, out_unit_x, out_unit_y, out_unit_z, out_zero_norm};
      if (pending_units.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result item: %p", got);
      end else begin
        want = pending_units.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result mismatch: expected w=%0d x=%0d y=%0d z=%0d zero=%0b, got w=%0d x=%0d y=%0d z=%0d zero=%0b",
                     want.w, want.x, want.y, want.z, want.zero,
                     got.w, got.x, got.y, got.z, got.zero);
        end
      end
    end
  end

  // End of run: wait for the last result, then let the pipeline settle.
  initial begin
    wait (stim_done);
    while (pending_units.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/qnorm_pkg.sv
rtl/core/qnorm_step.sv
rtl/core/quaternion_normaliser_unit.sv
tb/tb_top.sv
